FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// ASSERT_CLK_RST: property sampled on i_clk, ignored while reset is held.
// ASSERT_CLK: property sampled on i_clk, checked during reset too.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/ptfc_pkg.sv
// ----------------------------------------------------------------------------
// ptfc_pkg
// Types, register indexes and scaling helpers of the frequency tracker.
// ----------------------------------------------------------------------------
package ptfc_pkg;

    localparam int unsigned IDX_W    = 3;
    localparam int unsigned DATA_W   = 24;
    localparam int unsigned FREQ_W   = 16;
    localparam int unsigned MEAS_W   = 24;
    localparam int unsigned LIM_W    = FREQ_W + 1;

    localparam logic [FREQ_W-1:0] C_BASE_RESET = 16'd6000;

    // Reciprocal of 100 scaled by 2^30, folded with the percentage factor.
    localparam int unsigned PCT_SHIFT = 30;
    localparam logic [31:0] K_RECIP_100 = 32'd10737419;
    localparam logic [31:0] K_PCT_106   = 32'd106 * K_RECIP_100;
    localparam logic [31:0] K_PCT_96    = 32'd96 * K_RECIP_100;
    localparam logic [31:0] K_PCT_94    = 32'd94 * K_RECIP_100;
    localparam logic [31:0] K_PCT_104   = 32'd104 * K_RECIP_100;

    // Reciprocal of 10 scaled by 2^31, folded with the tenths factor.
    localparam int unsigned TENTH_SHIFT = 31;
    localparam logic [31:0] K_RECIP_10  = 32'd214748365;
    localparam logic [31:0] K_TENTH_11  = 32'd11 * K_RECIP_10;
    localparam logic [31:0] K_TENTH_9   = 32'd9 * K_RECIP_10;

    typedef enum logic [IDX_W-1:0] {
        CFG_BASE_FREQ   = 3'd0,
        CFG_LOCK_GATE   = 3'd1,
        CFG_TRACK_MIN   = 3'd2,
        CFG_SEARCH_MODE = 3'd3,
        CFG_TRACK_EN    = 3'd4
    } t_cfg_idx;

    // Configuration as seen by the tracking datapath, window limits
    // already scaled from the base frequency.
    typedef struct packed {
        logic [LIM_W-1:0]  win_hi;    // base * 106 / 100
        logic [LIM_W-1:0]  win_lo;    // base * 94 / 100
        logic [LIM_W-1:0]  wrap_lo;   // base * 96 / 100
        logic [LIM_W-1:0]  wrap_hi;   // base * 104 / 100
        logic [MEAS_W-1:0] gate;
        logic [MEAS_W:0]   gate_hi;   // gate * 11 / 10
        logic [MEAS_W-1:0] gate_lo;   // gate * 9 / 10
        logic              track_min;
        logic              search;
        logic              track_en;
    } t_cfg;

    typedef struct packed {
        logic [FREQ_W-1:0] drive_freq;
        logic              is_locked;
        logic [MEAS_W-1:0] extreme_seen;
    } t_res;

    function automatic logic [LIM_W-1:0] f_base_pct(input logic [FREQ_W-1:0] base,
                                                    input logic [31:0] k);
        logic [FREQ_W+31:0] prod;
        prod = {32'd0, base} * {{FREQ_W{1'b0}}, k};
        return prod[PCT_SHIFT +: LIM_W];
    endfunction

    function automatic logic [MEAS_W:0] f_gate_tenth(input logic [MEAS_W-1:0] gate,
                                                     input logic [31:0] k);
        logic [MEAS_W+31:0] prod;
        prod = {32'd0, gate} * {{MEAS_W{1'b0}}, k};
        return prod[TENTH_SHIFT +: (MEAS_W + 1)];
    endfunction

endpackage

FILE: hdl/ptfc_cfg.sv
// ----------------------------------------------------------------------------
// ptfc_cfg
// Configuration registers with window and gate limits scaled on write.
// ----------------------------------------------------------------------------
module ptfc_cfg
    import ptfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [IDX_W-1:0]  i_idx,
    input  logic [DATA_W-1:0] i_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [MEAS_W:0] gate_lo_full;

    always_comb begin
        n_cfg        = r_cfg;
        gate_lo_full = f_gate_tenth(i_data[MEAS_W-1:0], K_TENTH_9);
        if (i_wr) begin
            unique case (i_idx)
                CFG_BASE_FREQ: begin
                    n_cfg.win_hi  = f_base_pct(i_data[FREQ_W-1:0], K_PCT_106);
                    n_cfg.win_lo  = f_base_pct(i_data[FREQ_W-1:0], K_PCT_94);
                    n_cfg.wrap_lo = f_base_pct(i_data[FREQ_W-1:0], K_PCT_96);
                    n_cfg.wrap_hi = f_base_pct(i_data[FREQ_W-1:0], K_PCT_104);
                end
                CFG_LOCK_GATE: begin
                    n_cfg.gate    = i_data[MEAS_W-1:0];
                    n_cfg.gate_hi = f_gate_tenth(i_data[MEAS_W-1:0], K_TENTH_11);
                    n_cfg.gate_lo = gate_lo_full[MEAS_W-1:0];
                end
                CFG_TRACK_MIN:   n_cfg.track_min = i_data[0];
                CFG_SEARCH_MODE: n_cfg.search    = i_data[0];
                CFG_TRACK_EN:    n_cfg.track_en  = i_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_hi    <= f_base_pct(C_BASE_RESET, K_PCT_106);
            r_cfg.win_lo    <= f_base_pct(C_BASE_RESET, K_PCT_94);
            r_cfg.wrap_lo   <= f_base_pct(C_BASE_RESET, K_PCT_96);
            r_cfg.wrap_hi   <= f_base_pct(C_BASE_RESET, K_PCT_104);
            r_cfg.gate      <= '0;
            r_cfg.gate_hi   <= '0;
            r_cfg.gate_lo   <= '0;
            r_cfg.track_min <= 1'b0;
            r_cfg.search    <= 1'b0;
            r_cfg.track_en  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/ptfc_track.sv
// ----------------------------------------------------------------------------
// ptfc_track
// Tracker state and the combinational lock, direction and frequency update.
// ----------------------------------------------------------------------------
module ptfc_track
    import ptfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [MEAS_W-1:0] i_meas,
    input  t_cfg              i_cfg,
    output t_res              o_res
);

    localparam int unsigned PROD_W = FREQ_W + 11;

    logic [FREQ_W-1:0] r_freq, n_freq;
    logic [MEAS_W-1:0] r_prev, r_ext, n_ext;
    logic              r_up, n_up, r_lock, n_lock;
    logic              coarse;
    logic [PROD_W-1:0] delta, scaled;
    logic [LIM_W-1:0]  f_step, f_wrap;

    always_comb begin
        // lock detection
        n_lock = r_lock;
        if (i_cfg.search) begin
            if (i_cfg.track_min) begin
                if (i_meas < i_cfg.gate) begin
                    n_lock = 1'b1;
                end else if ({1'b0, i_meas} > i_cfg.gate_hi) begin
                    n_lock = 1'b0;
                end
            end else begin
                if (i_meas > i_cfg.gate) begin
                    n_lock = 1'b1;
                end else if (i_meas < i_cfg.gate_lo) begin
                    n_lock = 1'b0;
                end
            end
        end
        coarse = i_cfg.search && !n_lock;

        // direction and running extreme
        n_up  = r_up;
        n_ext = r_ext;
        if (i_cfg.track_min) begin
            if (i_meas > r_prev) n_up = !r_up;
            if (i_meas < r_ext) n_ext = i_meas;
        end else begin
            if (i_meas < r_prev) n_up = !r_up;
            if (i_meas > r_ext) n_ext = i_meas;
        end
        if (coarse) n_up = 1'b0;

        // freq * (1024 +/- step), step is 15 or 2
        if (coarse) begin
            delta = {{(PROD_W-FREQ_W-4){1'b0}}, r_freq, 4'b0}
                  - {{(PROD_W-FREQ_W){1'b0}}, r_freq};
        end else begin
            delta = {{(PROD_W-FREQ_W-1){1'b0}}, r_freq, 1'b0};
        end
        if (n_up) begin
            scaled = {1'b0, r_freq, 10'b0} + delta;
        end else begin
            scaled = {1'b0, r_freq, 10'b0} - delta;
        end
        f_step = scaled[PROD_W-1:10];

        // wrap back inside the window
        f_wrap = f_step;
        if (f_wrap > i_cfg.win_hi) f_wrap = i_cfg.wrap_lo;
        if (f_wrap < i_cfg.win_lo) f_wrap = i_cfg.wrap_hi;

        if (!i_cfg.track_en) begin
            n_freq = r_freq;
            n_up   = r_up;
            n_ext  = r_ext;
        end else if (f_wrap[LIM_W-1]) begin
            n_freq = '1;
        end else begin
            n_freq = f_wrap[FREQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= C_BASE_RESET;
            r_prev <= '0;
            r_up   <= 1'b1;
            r_lock <= 1'b0;
            r_ext  <= '0;
        end else if (i_go) begin
            r_freq <= n_freq;
            r_prev <= i_meas;
            r_up   <= n_up;
            r_lock <= n_lock;
            r_ext  <= n_ext;
        end
    end

    assign o_res.drive_freq   = n_freq;
    assign o_res.is_locked    = n_lock;
    assign o_res.extreme_seen = n_ext;

endmodule

FILE: hdl/power_tracking_freq_climb.sv
// ----------------------------------------------------------------------------
// power_tracking_freq_climb
// Perturb-and-observe drive-frequency tracker, one result per measurement.
// ----------------------------------------------------------------------------
// Each transfer on the input channel carries one power measurement and
// produces exactly one result transfer: the drive frequency after the step,
// the lock flag and the running extreme of the measurement. A measurement
// lands in an input register; when the result register is free the tracker
// updates its state from it and loads the result register, which drives
// the outputs. The block sustains one measurement per clock as long as the
// output side keeps up. The rate is set by the state feedback loop in the
// tracker, which does the multiplicative step and the window wrap
// combinationally. When the result register is held by the output stall the
// input register fills and then the input stall rises. Configuration
// writes are always ready; window limits are scaled from the base
// frequency when it is written, so write registers only while no
// measurement is in flight.
module power_tracking_freq_climb
    import ptfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // measurement channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [MEAS_W-1:0] i_measurement,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [FREQ_W-1:0] o_drive_freq,
    output logic              o_is_locked,
    output logic [MEAS_W-1:0] o_extreme_seen,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [DATA_W-1:0] i_cfg_data
);

    t_cfg              cfg;
    t_res              res;
    logic              r_in_vld;
    logic [MEAS_W-1:0] r_in_meas;
    logic              r_out_vld;
    t_res              r_out;
    logic              advance;
    logic              in_take;

    // configuration is taken in any cycle
    assign o_cfg_ready = 1'b1;

    ptfc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // advance the held measurement when the result register is free
    assign advance    = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    ptfc_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_in_vld && advance),
        .i_meas  (r_in_meas),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // input register: load on transfer, drop once it moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_meas <= i_measurement;
        end
    end

    // result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_vld) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_drive_freq   = r_out.drive_freq;
    assign o_is_locked    = r_out.is_locked;
    assign o_extreme_seen = r_out.extreme_seen;

endmodule

FILE: hdl/ptfc_checker.sv
// ----------------------------------------------------------------------------
// ptfc_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptfc_checker
    import ptfc_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [FREQ_W-1:0] o_drive_freq,
    input logic              o_is_locked,
    input logic [MEAS_W-1:0] o_extreme_seen
);

    logic [FREQ_W+MEAS_W:0] out_word;

    assign out_word = {o_drive_freq, o_is_locked, o_extreme_seen};

    `ASSERT_CLK_RST(a_out_valid_holds, o_out_valid && i_out_stall |=> o_out_valid, "valid dropped")
    `ASSERT_CLK_RST(a_out_data_holds, o_out_valid && i_out_stall |=> $stable(out_word), "data changed")
    `ASSERT_CLK(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `ASSERT_CLK_RST(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "stall without cause")
    `ASSERT_CLK_RST(a_result_arrives, i_in_valid && !o_in_stall |-> ##2 o_out_valid, "result late")

endmodule

bind power_tracking_freq_climb ptfc_checker u_ptfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_drive_freq   (o_drive_freq),
    .o_is_locked    (o_is_locked),
    .o_extreme_seen (o_extreme_seen)
);
